// File: rtl/core/point_on_plane_jacobian_assert.svh
`ifndef POINT_ON_PLANE_JACOBIAN_ASSERT_SVH
`define POINT_ON_PLANE_JACOBIAN_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define POPJ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define POPJ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/popj_pkg.sv
package popj_pkg;
  localparam int unsigned QW = 16;
  localparam int unsigned QFRAC = 14;
  // fraction bits of a vector component
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned THR_W = 19;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_PLANE_ANCHOR = 3'd0,
    REG_PLANE_NORMAL = 3'd1,
    REG_ANCHOR_B     = 3'd2,
    REG_GAIN         = 3'd3,
    REG_THRESHOLD    = 3'd4
  } cfg_reg_e;

  // pipeline handshake between stage registers
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;
endpackage

// File: rtl/core/point_on_plane_jacobian.sv
// Point-on-plane constraint jacobian. One transaction per cycle unless stalled.
// Stages: two rotation stages, a sum stage, a dot/cross product stage, a rounding stage
// and the gain product with the output register. Valid bits travel with the data and the
// whole pipe holds while the output is stalled. Config must be written while idle.
module point_on_plane_jacobian #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [popj_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [popj_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [3*COORD_WIDTH-1:0]       bone_a_position_i,
  input  logic [4*popj_pkg::QW-1:0]      bone_a_rotation_i,
  input  logic [3*COORD_WIDTH-1:0]       bone_b_position_i,
  input  logic [4*popj_pkg::QW-1:0]      bone_b_rotation_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [3*popj_pkg::QW-1:0]      axis_direction_o,
  output logic [3*COORD_WIDTH-1:0]       angular_a_o,
  output logic [3*COORD_WIDTH-1:0]       angular_b_o,
  output logic signed [COORD_WIDTH-1:0]  distance_error_o,
  output logic signed [COORD_WIDTH-1:0]  velocity_bias_o,
  output logic                           has_error_o
);
`include "point_on_plane_jacobian_assert.svh"
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned QW = popj_pkg::QW;
  localparam int unsigned RW = CW + 6;
  localparam int unsigned NRW = QW + 6;
  localparam int unsigned SW = RW + 3;
  localparam int unsigned PW = SW + NRW + 2;
  localparam int unsigned GW = popj_pkg::GAIN_W;
  localparam int unsigned NST = 6;

  logic [3*CW-1:0] anchor_a_q, anchor_b_q;
  logic [3*QW-1:0] normal_q;
  logic [GW-1:0] gain_q;
  logic [popj_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_a_q <= '0; normal_q <= '0; anchor_b_q <= '0; gain_q <= '0;
      thr_q <= popj_pkg::THR_W'(2);
    end else if (cfg_we_i) begin
      case (popj_pkg::cfg_reg_e'(cfg_idx_i))
        popj_pkg::REG_PLANE_ANCHOR: anchor_a_q <= cfg_data_i[3*CW-1:0];
        popj_pkg::REG_PLANE_NORMAL: normal_q <= cfg_data_i[3*QW-1:0];
        popj_pkg::REG_ANCHOR_B:     anchor_b_q <= cfg_data_i[3*CW-1:0];
        popj_pkg::REG_GAIN:         gain_q <= cfg_data_i[GW-1:0];
        popj_pkg::REG_THRESHOLD:    thr_q <= cfg_data_i[popj_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: everything moves unless the output holds a stalled transaction
  logic [NST-1:0] vld_q;
  popj_pkg::stage_ctl_t ctl;
  assign ctl.advance = !out_valid_o || out_ready_i;
  assign ctl.valid = in_valid_i;
  assign in_ready_o = ctl.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (ctl.advance) vld_q <= {vld_q[NST-2:0], ctl.valid};
  end
  assign out_valid_o = vld_q[NST-1];

  // stage 1-2: rotations
  logic signed [RW-1:0] oax, oay, oaz, obx, oby, obz;
  logic signed [NRW-1:0] nx, ny, nz;
  logic [3*CW-1:0] pa_q1, pa_q2, pb_q1, pb_q2;

  popj_rotate #(.VW(CW)) u_rot_a (.clk_i, .en_i(ctl.advance), .quat_i(bone_a_rotation_i),
    .vx_i(anchor_a_q[CW-1:0]), .vy_i(anchor_a_q[2*CW-1:CW]), .vz_i(anchor_a_q[3*CW-1:2*CW]),
    .rx_o(oax), .ry_o(oay), .rz_o(oaz));
  popj_rotate #(.VW(QW)) u_rot_n (.clk_i, .en_i(ctl.advance), .quat_i(bone_a_rotation_i),
    .vx_i(normal_q[QW-1:0]), .vy_i(normal_q[2*QW-1:QW]), .vz_i(normal_q[3*QW-1:2*QW]),
    .rx_o(nx), .ry_o(ny), .rz_o(nz));
  popj_rotate #(.VW(CW)) u_rot_b (.clk_i, .en_i(ctl.advance), .quat_i(bone_b_rotation_i),
    .vx_i(anchor_b_q[CW-1:0]), .vy_i(anchor_b_q[2*CW-1:CW]), .vz_i(anchor_b_q[3*CW-1:2*CW]),
    .rx_o(obx), .ry_o(oby), .rz_o(obz));

  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      pa_q1 <= bone_a_position_i; pb_q1 <= bone_b_position_i;
      pa_q2 <= pa_q1; pb_q2 <= pb_q1;
    end
  end

  // stage 3: sums
  logic signed [SW-1:0] sep_q [3];
  logic signed [SW-1:0] ra_q [3];
  logic signed [RW-1:0] ob_q3 [3];
  logic signed [NRW-1:0] n_q3 [3];
  logic signed [RW-1:0] oa_w [3];
  logic signed [RW-1:0] ob_w [3];
  logic signed [NRW-1:0] n_w [3];
  assign oa_w = '{oax, oay, oaz};
  assign ob_w = '{obx, oby, obz};
  assign n_w = '{nx, ny, nz};

  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      for (int i = 0; i < 3; i++) begin
        sep_q[i] <= SW'($signed(pb_q2[i*CW +: CW])) + SW'(ob_w[i])
                    - SW'($signed(pa_q2[i*CW +: CW])) - SW'(oa_w[i]);
        ra_q[i] <= SW'($signed(pb_q2[i*CW +: CW])) + SW'(ob_w[i])
                   - SW'($signed(pa_q2[i*CW +: CW]));
        ob_q3[i] <= ob_w[i];
        n_q3[i] <= n_w[i];
      end
    end
  end

  // stage 4: dot and crosses at full width
  logic signed [PW:0] dot_q;
  logic signed [PW-1:0] ca_q [3];
  logic signed [PW-1:0] cb_q [3];
  logic signed [NRW-1:0] n_q4 [3];
  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      dot_q <= (PW+1)'(sep_q[0]) * (PW+1)'(n_q3[0]) + (PW+1)'(sep_q[1]) * (PW+1)'(n_q3[1])
             + (PW+1)'(sep_q[2]) * (PW+1)'(n_q3[2]);
      ca_q[0] <= PW'(ra_q[1]) * PW'(n_q3[2]) - PW'(ra_q[2]) * PW'(n_q3[1]);
      ca_q[1] <= PW'(ra_q[2]) * PW'(n_q3[0]) - PW'(ra_q[0]) * PW'(n_q3[2]);
      ca_q[2] <= PW'(ra_q[0]) * PW'(n_q3[1]) - PW'(ra_q[1]) * PW'(n_q3[0]);
      cb_q[0] <= PW'(n_q3[1]) * PW'(ob_q3[2]) - PW'(n_q3[2]) * PW'(ob_q3[1]);
      cb_q[1] <= PW'(n_q3[2]) * PW'(ob_q3[0]) - PW'(n_q3[0]) * PW'(ob_q3[2]);
      cb_q[2] <= PW'(n_q3[0]) * PW'(ob_q3[1]) - PW'(n_q3[1]) * PW'(ob_q3[0]);
      n_q4 <= n_q3;
    end
  end

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [PW:0] x);
    logic signed [PW:0] hi, lo;
    hi = (PW+1)'((64'sd1 <<< (CW - 1)) - 1);
    lo = -hi - 1;
    if (x > hi) sat_cw = CW'(hi);
    else if (x < lo) sat_cw = CW'(lo);
    else sat_cw = CW'(x);
  endfunction

  function automatic logic signed [QW-1:0] sat_qw(input logic signed [NRW-1:0] x);
    logic signed [NRW-1:0] hi, lo;
    hi = NRW'((32'sd1 <<< (QW - 1)) - 1);
    lo = -hi - 1;
    if (x > hi) sat_qw = QW'(hi);
    else if (x < lo) sat_qw = QW'(lo);
    else sat_qw = QW'(x);
  endfunction

  localparam int unsigned QF = popj_pkg::QFRAC;
  // stage 5: rounding, saturation
  logic signed [CW-1:0] dist_q5;
  logic [3*CW-1:0] ca_q5, cb_q5;
  logic [3*QW-1:0] n_q5;
  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      dist_q5 <= sat_cw((dot_q + (PW+1)'(1 <<< (QF - 1))) >>> QF);
      for (int i = 0; i < 3; i++) begin
        ca_q5[i*CW +: CW] <= sat_cw((PW+1)'((ca_q[i] + PW'(1 <<< (QF - 1))) >>> QF));
        cb_q5[i*CW +: CW] <= sat_cw((PW+1)'((cb_q[i] + PW'(1 <<< (QF - 1))) >>> QF));
        n_q5[i*QW +: QW] <= sat_qw(n_q4[i]);
      end
    end
  end

  // stage 6: gain product, flag, output register
  localparam int unsigned BW = CW + GW + 2;
  logic signed [BW-1:0] bprod;
  logic [CW-1:0] mag;
  assign bprod = BW'(dist_q5) * $signed({1'b0, gain_q}) + BW'(1 <<< (GW - 1));
  assign mag = dist_q5[CW-1] ? CW'(-dist_q5) : CW'(dist_q5);

  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      distance_error_o <= dist_q5;
      velocity_bias_o <= sat_cw((PW+1)'(bprod >>> GW));
      has_error_o <= 32'(mag) >= 32'(thr_q);
      angular_a_o <= ca_q5;
      angular_b_o <= cb_q5;
      axis_direction_o <= n_q5;
    end
  end

  `POPJ_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `POPJ_ASSERT_IMPL(a_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `POPJ_ASSERT_NEXT(a_flow, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0])
endmodule

// File: rtl/core/popj_rotate.sv
// two-stage quaternion rotation: t = 2(q x v) registered, then v + w t + q x t
module popj_rotate #(
  parameter int unsigned VW = 20
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [4*popj_pkg::QW-1:0]  quat_i,
  input  logic signed [VW-1:0]       vx_i,
  input  logic signed [VW-1:0]       vy_i,
  input  logic signed [VW-1:0]       vz_i,
  output logic signed [VW+5:0]       rx_o,
  output logic signed [VW+5:0]       ry_o,
  output logic signed [VW+5:0]       rz_o
);
  localparam int unsigned QW = popj_pkg::QW;
  localparam int unsigned SH = 2 * popj_pkg::QFRAC;
  localparam int unsigned TW = VW + QW + 2;
  localparam int unsigned AW = TW + QW + 4;
  localparam int unsigned RW = VW + 6;

  logic signed [QW-1:0] qx, qy, qz, qw;
  logic signed [TW-1:0] tx, ty, tz;
  logic signed [TW-1:0] tx_q, ty_q, tz_q;
  logic signed [QW-1:0] qx_q, qy_q, qz_q, qw_q;
  logic signed [VW-1:0] vx_q, vy_q, vz_q;
  logic signed [AW-1:0] ax, ay, az;

  assign qx = quat_i[QW-1:0];
  assign qy = quat_i[2*QW-1:QW];
  assign qz = quat_i[3*QW-1:2*QW];
  assign qw = quat_i[4*QW-1:3*QW];

  assign tx = (TW'(qy) * TW'(vz_i) - TW'(qz) * TW'(vy_i)) <<< 1;
  assign ty = (TW'(qz) * TW'(vx_i) - TW'(qx) * TW'(vz_i)) <<< 1;
  assign tz = (TW'(qx) * TW'(vy_i) - TW'(qy) * TW'(vx_i)) <<< 1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx_q <= tx; ty_q <= ty; tz_q <= tz;
      qx_q <= qx; qy_q <= qy; qz_q <= qz; qw_q <= qw;
      vx_q <= vx_i; vy_q <= vy_i; vz_q <= vz_i;
    end
  end

  assign ax = (AW'(vx_q) <<< SH) + AW'(qw_q) * AW'(tx_q) + AW'(qy_q) * AW'(tz_q)
              - AW'(qz_q) * AW'(ty_q);
  assign ay = (AW'(vy_q) <<< SH) + AW'(qw_q) * AW'(ty_q) + AW'(qz_q) * AW'(tx_q)
              - AW'(qx_q) * AW'(tz_q);
  assign az = (AW'(vz_q) <<< SH) + AW'(qw_q) * AW'(tz_q) + AW'(qx_q) * AW'(ty_q)
              - AW'(qy_q) * AW'(tx_q);

  // round to nearest, ties up: add half then floor shift
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_o <= RW'((ax + (AW'(1) <<< (SH - 1))) >>> SH);
      ry_o <= RW'((ay + (AW'(1) <<< (SH - 1))) >>> SH);
      rz_o <= RW'((az + (AW'(1) <<< (SH - 1))) >>> SH);
    end
  end
endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 20;
  localparam int FB = 14;
  localparam int SETTLE = 12;
  localparam int STALL_LIMIT = 2000;
  localparam logic [popj_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [3*CW-1:0] pos_a;
    logic [4*popj_pkg::QW-1:0] rot_a;
    logic [3*CW-1:0] pos_b;
    logic [4*popj_pkg::QW-1:0] rot_b;
  } bone_pair_t;

  typedef struct {
    logic [3*popj_pkg::QW-1:0] axis;
    logic [3*CW-1:0] ang_a;
    logic [3*CW-1:0] ang_b;
    logic [CW-1:0]   dist_err;
    logic [CW-1:0]   bias;
    logic            err;
  } jacobian_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [popj_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [popj_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3*CW-1:0] bone_a_position_i = '0;
  logic [4*popj_pkg::QW-1:0] bone_a_rotation_i = '0;
  logic [3*CW-1:0] bone_b_position_i = '0;
  logic [4*popj_pkg::QW-1:0] bone_b_rotation_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [3*popj_pkg::QW-1:0] axis_direction_o;
  logic [3*CW-1:0] angular_a_o;
  logic [3*CW-1:0] angular_b_o;
  logic signed [CW-1:0] distance_error_o;
  logic signed [CW-1:0] velocity_bias_o;
  logic has_error_o;

  point_on_plane_jacobian dut (.*);

  // mirrored register file
  logic [63:0] plane_anchor = '0;
  logic [63:0] plane_normal = '0;
  logic [63:0] anchor_b = '0;
  logic [63:0] gain = '0;
  logic [63:0] threshold = 64'd2;

  bone_pair_t pending[$];
  jacobian_t  expected[$];
  bit idle_on = 1'b1;
  bit in_taken = 1'b0;
  int in_gap = 0, out_gap = 0, stall = 0, errors = 0, n_in = 0, n_out = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mask(int w);
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic longint sx(logic [63:0] v, int w);
    logic [63:0] m;
    m = v & mask(w);
    return m[w-1] ? longint'(m) - (longint'(1) <<< w) : longint'(m);
  endfunction

  function automatic longint rnd(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint satw(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic void unpack3(logic [63:0] p, int w, output longint v[3]);
    for (int i = 0; i < 3; i++) v[i] = sx(p >> (i * w), w);
  endfunction

  function automatic logic [63:0] pack3(longint v[3], int w);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 3; i++) r |= (64'(satw(v[i], w)) & mask(w)) << (i * w);
    return r;
  endfunction

  function automatic void cross3(longint a[3], longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // v' = v + w*t + q x t with t = 2 (q x v), one rounding at the end
  function automatic void rotate(logic [63:0] qp, longint v[3], output longint r[3]);
    longint q[3], t[3], u[3];
    longint w;
    w = sx(qp >> 48, popj_pkg::QW);
    for (int i = 0; i < 3; i++) q[i] = sx(qp >> (i * popj_pkg::QW), popj_pkg::QW);
    cross3(q, v, t);
    for (int i = 0; i < 3; i++) t[i] = 2 * t[i];
    cross3(q, t, u);
    for (int i = 0; i < 3; i++)
      r[i] = rnd((v[i] <<< (2 * popj_pkg::QFRAC)) + w * t[i] + u[i], 2 * popj_pkg::QFRAC);
  endfunction

  function automatic jacobian_t solve_jacobian(bone_pair_t b);
    longint la[3], ln[3], lb[3], pa[3], pb[3];
    longint offa[3], n[3], offb[3], ra[3], ca[3], cb[3];
    longint ancb, dot, dist_err, bias, mag;
    jacobian_t r;
    unpack3(plane_anchor, CW, la);
    unpack3(plane_normal, popj_pkg::QW, ln);
    unpack3(anchor_b, CW, lb);
    unpack3(64'(b.pos_a), CW, pa);
    unpack3(64'(b.pos_b), CW, pb);
    rotate(b.rot_a, la, offa);
    rotate(b.rot_a, ln, n);
    rotate(b.rot_b, lb, offb);
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      ancb = pb[i] + offb[i];
      ra[i] = ancb - pa[i];
      dot += (ancb - (pa[i] + offa[i])) * n[i];
    end
    dist_err = satw(rnd(dot, FB), CW);
    bias = satw(rnd(dist_err * longint'(gain), 16), CW);
    mag = dist_err < 0 ? -dist_err : dist_err;
    cross3(ra, n, ca);
    cross3(n, offb, cb);
    for (int i = 0; i < 3; i++) begin
      ca[i] = rnd(ca[i], FB);
      cb[i] = rnd(cb[i], FB);
    end
    r.axis = pack3(n, popj_pkg::QW);
    r.ang_a = pack3(ca, CW);
    r.ang_b = pack3(cb, CW);
    r.dist_err = dist_err[CW-1:0];
    r.bias = bias[CW-1:0];
    r.err = 64'(mag) >= threshold;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // unit quaternion: identity, quarter or half turn about an axis, random sign
  function automatic logic [63:0] unit_quat();
    logic signed [15:0] c[4];
    int ax;
    logic [63:0] r;
    ax = $urandom_range(0, 2);
    c = '{default: 16'sd0};
    case ($urandom_range(0, 2))
      0: c[3] = 16'sd16384;
      1: begin
        c[3] = 16'sd11585;
        c[ax] = 16'sd11585;
      end
      default: c[ax] = 16'sd16384;
    endcase
    if ($urandom_range(0, 1)) for (int i = 0; i < 4; i++) c[i] = -c[i];
    r = '0;
    for (int i = 0; i < 4; i++) r |= 64'($unsigned(c[i])) << (16 * i);
    return r;
  endfunction

  function automatic logic [63:0] small_vec();
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 3; i++)
      r |= (64'($signed($urandom_range(0, 65535)) - 32768) & mask(CW)) << (i * CW);
    return r;
  endfunction

  function automatic bone_pair_t random_pair();
    bone_pair_t b;
    if ($urandom_range(0, 3) == 0) begin
      b.pos_a = (3*CW)'(rand64());
      b.rot_a = rand64();
      b.pos_b = (3*CW)'(rand64());
      b.rot_b = rand64();
    end else begin
      b.pos_a = (3*CW)'(small_vec());
      b.rot_a = unit_quat();
      b.pos_b = (3*CW)'(small_vec());
      b.rot_b = unit_quat();
    end
    return b;
  endfunction

  task automatic write_reg(logic [popj_pkg::IDX_W-1:0] idx, logic [63:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      popj_pkg::REG_PLANE_ANCHOR: plane_anchor = d & mask(60);
      popj_pkg::REG_PLANE_NORMAL: plane_normal = d & mask(48);
      popj_pkg::REG_ANCHOR_B:     anchor_b = d & mask(60);
      popj_pkg::REG_GAIN:         gain = d & mask(popj_pkg::GAIN_W);
      popj_pkg::REG_THRESHOLD:    threshold = d & mask(popj_pkg::THR_W);
      default: ;
    endcase
  endtask

  task automatic configure(logic [63:0] pa, logic [63:0] pn, logic [63:0] ab,
                           logic [63:0] g, logic [63:0] th);
    write_reg(popj_pkg::REG_PLANE_ANCHOR, pa);
    write_reg(popj_pkg::REG_PLANE_NORMAL, pn);
    write_reg(popj_pkg::REG_ANCHOR_B, ab);
    write_reg(popj_pkg::REG_GAIN, g);
    write_reg(popj_pkg::REG_THRESHOLD, th);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || expected.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) pending.push_back(random_pair());
    drain();
  endtask

  // driver
  always @(negedge clk_i) begin
    bone_pair_t b;
    if (!in_valid_i || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 5);
        in_valid_i <= 1'b0;
      end else if (pending.size() != 0) begin
        b = pending.pop_front();
        in_valid_i <= 1'b1;
        bone_a_position_i <= b.pos_a;
        bone_a_rotation_i <= b.rot_a;
        bone_b_position_i <= b.pos_b;
        bone_b_rotation_i <= b.rot_b;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    bone_pair_t b;
    jacobian_t e;
    bit moved;
    moved = 1'b0;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      b.pos_a = bone_a_position_i;
      b.rot_a = bone_a_rotation_i;
      b.pos_b = bone_b_position_i;
      b.rot_b = bone_b_rotation_i;
      expected.push_back(solve_jacobian(b));
      n_in++;
      moved = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      moved = 1'b1;
      if (expected.size() == 0) begin
        $display("%0t: unexpected transaction on output", $realtime);
        errors++;
      end else begin
        e = expected.pop_front();
        if (axis_direction_o !== e.axis) begin
          $display("%0t: axis_direction exp %h got %h", $realtime, e.axis, axis_direction_o);
          errors++;
        end
        if (angular_a_o !== e.ang_a) begin
          $display("%0t: angular_a exp %h got %h", $realtime, e.ang_a, angular_a_o);
          errors++;
        end
        if (angular_b_o !== e.ang_b) begin
          $display("%0t: angular_b exp %h got %h", $realtime, e.ang_b, angular_b_o);
          errors++;
        end
        if (distance_error_o !== e.dist_err) begin
          $display("%0t: distance_error exp %h got %h", $realtime, e.dist_err,
                   distance_error_o);
          errors++;
        end
        if (velocity_bias_o !== e.bias) begin
          $display("%0t: velocity_bias exp %h got %h", $realtime, e.bias, velocity_bias_o);
          errors++;
        end
        if (has_error_o !== e.err) begin
          $display("%0t: has_error exp %b got %b", $realtime, e.err, has_error_o);
          errors++;
        end
      end
    end
    if (rst_ni) begin
      if (moved || (pending.size() == 0 && !in_valid_i && expected.size() == 0)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $realtime, stall);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    bone_pair_t b;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults first, then directed corners
    b = '{pos_a: '0, rot_a: 64'h4000_0000_0000_0000, pos_b: '0, rot_b: 64'h4000_0000_0000_0000};
    pending.push_back(b);
    drain();
    configure(64'h0000_4000_0000_4000, 64'h4000_0000_0000, 64'h0_0000_0000_4000,
              64'h8000, 64'd1 << 14);
    b.pos_b = 60'h00000_04000_00000;
    pending.push_back(b);
    b = '{pos_a: '1, rot_a: '1, pos_b: '1, rot_b: '1};
    pending.push_back(b);
    b = '{pos_a: {3{20'h7ffff}}, rot_a: {4{16'h7fff}}, pos_b: {3{20'h80000}},
          rot_b: {4{16'h8000}}};
    pending.push_back(b);
    b = '{pos_a: {3{20'h80000}}, rot_a: {4{16'h8000}}, pos_b: {3{20'h7ffff}},
          rot_b: {4{16'h7fff}}};
    pending.push_back(b);
    for (int i = 0; i < 8; i++) pending.push_back(random_pair());
    drain();
    // extreme registers, zero threshold, ignored index
    configure(64'({3{20'h7ffff}}), 64'({3{16'h7fff}}), 64'({3{20'h80000}}), 64'hffff,
              64'd0);
    write_reg(REG_UNUSED, '1);
    pending.push_back(b);
    b = '{pos_a: '0, rot_a: '0, pos_b: '0, rot_b: '0};
    pending.push_back(b);
    for (int i = 0; i < 8; i++) pending.push_back(random_pair());
    drain();

    configure(small_vec(), 64'h0000_0000_4000, small_vec(), 64'($urandom_range(0, 65535)),
              64'($urandom_range(0, 4096)));
    run_random(350);
    configure(rand64(), rand64(), rand64(), rand64(), rand64());
    run_random(350);
    configure('0, 64'h0000_4000_0000, '0, 64'hffff, mask(popj_pkg::THR_W));
    run_random(350);
    configure(small_vec(), 64'hc000_0000_0000, small_vec(), 64'($urandom_range(0, 65535)),
              64'($urandom_range(0, 1 << 16)));
    run_random(350);
    idle_on = 1'b0;
    configure(small_vec(), rand64(), small_vec(), rand64(), rand64());
    run_random(350);

    $display("covered %0d bone pairs and %0d jacobians over 8 register settings,",
             n_in, n_out);
    $display("with random stalls on both sides and a final stretch at full rate");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
